[hdl/assert_macros.svh]
// Assertion macros for the RTL, included by linear_solve_2x2.
// All of them are clocked on aclk and are disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ls2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ls2_pkg
// Types and constants for the 2x2 Cramer's rule solver.
// ----------------------------------------------------------------------------
package ls2_pkg;

    localparam int unsigned ELEM_W   = 32;   // Q16.16 element
    localparam int unsigned PROD_W   = 64;   // Q32.32 product
    localparam int unsigned SUM_W    = 65;   // difference of two products
    localparam int unsigned QBITS    = 32;   // quotient bits, one per cell
    localparam int unsigned FRAC_W   = 16;
    localparam logic [31:0] THR_RESET = 32'd42950;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN   = 32'h8000_0000;

    // Word carried along the divider chain
    typedef struct packed {
        logic [PROD_W-1:0] d;       // divisor, |det|
        logic [PROD_W-1:0] r0;      // partial remainder for x0
        logic [PROD_W-1:0] r1;      // partial remainder for x1
        logic [QBITS-1:0]  q0;      // dividend bits out, quotient bits in
        logic [QBITS-1:0]  q1;
        logic              solved;
        logic              big0;    // quotient for x0 reaches 2^32
        logic              big1;
        logic              neg0;    // operand signs differ
        logic              neg1;
    } div_word_t;

endpackage

[hdl/linear_solve_2x2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_solve_2x2
// Solves A*x = b for a 2x2 system in Q16.16 by Cramer's rule.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata: a00 a01 a10 a11 b0 b1
//  m_        out  m_tvalid / m_tready       m_tdata: x0 x1, m_tuser: solved sat
//  cfg       in   cfg_wr_en                 cfg_wr_data: det_threshold
//
//  One word enters per cycle while the skid word is empty. The stages are:
//  products, sums, magnitudes and compares, 32 division cells (one quotient
//  bit each), and the output fixup register.
//  The chain moves on one enable; a skid word behind the output register
//  takes the word leaving the chain when the sink stalls; then the chain holds.
//  Reset clears valid bits and loads det_threshold with 42950.
// ----------------------------------------------------------------------------
module linear_solve_2x2
    import ls2_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // a00, a01, a10, a11, b0, b1 from bit 0 up
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // x0, x1 from bit 0 up
    output logic [1:0]   m_tuser,   // solved, saturated from bit 0 up
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data
);

`include "assert_macros.svh"

    logic        en;
    logic [31:0] det_threshold_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_threshold_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            det_threshold_reg <= cfg_wr_data;
        end
    end

    // Unpack the input word
    logic signed [ELEM_W-1:0] a00, a01, a10, a11, b0, b1;
    assign a00 = s_tdata[31:0];
    assign a01 = s_tdata[63:32];
    assign a10 = s_tdata[95:64];
    assign a11 = s_tdata[127:96];
    assign b0  = s_tdata[159:128];
    assign b1  = s_tdata[191:160];

    // Stage 1: the six products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] p_a00a11_reg, p_a01a10_reg, p_a11b0_reg;
    logic signed [PROD_W-1:0] p_a01b1_reg, p_a00b1_reg, p_a10b0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_a00a11_reg <= PROD_W'(a00) * PROD_W'(a11);
            p_a01a10_reg <= PROD_W'(a01) * PROD_W'(a10);
            p_a11b0_reg  <= PROD_W'(a11) * PROD_W'(b0);
            p_a01b1_reg  <= PROD_W'(a01) * PROD_W'(b1);
            p_a00b1_reg  <= PROD_W'(a00) * PROD_W'(b1);
            p_a10b0_reg  <= PROD_W'(a10) * PROD_W'(b0);
        end
    end

    // Stage 2: determinant and numerators
    logic                    v2_reg;
    logic signed [SUM_W-1:0] det_reg, n0_reg, n1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= SUM_W'(p_a00a11_reg) - SUM_W'(p_a01a10_reg);
            n0_reg  <= SUM_W'(p_a11b0_reg) - SUM_W'(p_a01b1_reg);
            n1_reg  <= SUM_W'(p_a00b1_reg) - SUM_W'(p_a10b0_reg);
        end
    end

    // Stage 3: magnitudes, singular test, overflow test; build the chain word
    logic              v3_reg;
    div_word_t         w3_reg;
    div_word_t         w3_next;
    logic [SUM_W-1:0]  dabs, n0abs, n1abs;
    logic [PROD_W-1:0] dmag, n0mag, n1mag;

    always_comb begin
        dabs  = det_reg[SUM_W-1] ? SUM_W'(-det_reg) : SUM_W'(det_reg);
        n0abs = n0_reg[SUM_W-1]  ? SUM_W'(-n0_reg)  : SUM_W'(n0_reg);
        n1abs = n1_reg[SUM_W-1]  ? SUM_W'(-n1_reg)  : SUM_W'(n1_reg);
        dmag  = dabs[PROD_W-1:0];
        n0mag = n0abs[PROD_W-1:0];
        n1mag = n1abs[PROD_W-1:0];
        w3_next.d      = dmag;
        w3_next.solved = (dmag != '0) && (dmag >= PROD_W'(det_threshold_reg));
        // quotient reaches 2^32 when |n| >= |det| * 2^16
        w3_next.big0   = {16'b0, n0mag} >= {dmag, 16'b0};
        w3_next.big1   = {16'b0, n1mag} >= {dmag, 16'b0};
        w3_next.neg0   = n0_reg[SUM_W-1] ^ det_reg[SUM_W-1];
        w3_next.neg1   = n1_reg[SUM_W-1] ^ det_reg[SUM_W-1];
        // dividend is |n| << 16; upper 48 bits seed the remainder
        w3_next.r0     = {16'b0, n0mag[PROD_W-1:FRAC_W]};
        w3_next.r1     = {16'b0, n1mag[PROD_W-1:FRAC_W]};
        w3_next.q0     = {n0mag[FRAC_W-1:0], 16'b0};
        w3_next.q1     = {n1mag[FRAC_W-1:0], 16'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w3_reg <= w3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Division chain: one quotient bit per cell
    logic      cv [QBITS+1];
    div_word_t cw [QBITS+1];

    assign cv[0] = v3_reg;
    assign cw[0] = w3_reg;

    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        ls2_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[k]),
            .in_word   (cw[k]),
            .out_valid (cv[k+1]),
            .out_word  (cw[k+1])
        );
    end

    // Sign and saturation fixup
    div_word_t   wl;
    logic [31:0] x0_res, x1_res;
    logic        sat0, sat1, res_solved, res_sat;
    logic        neg0, neg1;

    always_comb begin
        wl = cw[QBITS];
        neg0 = wl.neg0 && (wl.big0 || (wl.q0 != '0));
        neg1 = wl.neg1 && (wl.big1 || (wl.q1 != '0));
        if (!neg0) begin
            sat0   = wl.big0 || wl.q0[31];
            x0_res = sat0 ? POS_MAX : wl.q0;
        end else begin
            sat0   = wl.big0 || (wl.q0 > NEG_MIN);
            x0_res = sat0 ? NEG_MIN : 32'(-wl.q0);
        end
        if (!neg1) begin
            sat1   = wl.big1 || wl.q1[31];
            x1_res = sat1 ? POS_MAX : wl.q1;
        end else begin
            sat1   = wl.big1 || (wl.q1 > NEG_MIN);
            x1_res = sat1 ? NEG_MIN : 32'(-wl.q1);
        end
        res_solved = wl.solved;
        res_sat    = wl.solved && (sat0 || sat1);
        // singular system: drop the quotients
        if (!wl.solved) begin
            x0_res = '0;
            x1_res = '0;
        end
    end

    // Output register and skid word
    logic        m_valid_reg, skid_valid_reg;
    logic [63:0] m_data_reg, skid_data_reg;
    logic [1:0]  m_user_reg, skid_user_reg;
    logic        last_fire;

    assign en        = !skid_valid_reg;
    assign last_fire = en && cv[QBITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            // output slot free: drain the skid first, else take the chain
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= last_fire;
            end
        end else if (last_fire) begin
            // sink stalled: park the word
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= {x1_res, x0_res};
                m_user_reg <= {res_sat, res_solved};
            end
        end else if (last_fire) begin
            skid_data_reg <= {x1_res, x0_res};
            skid_user_reg <= {res_sat, res_solved};
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    `ASSERT_IMP(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `ASSERT_NEXT(a_skid_fill, m_valid_reg && !m_tready && last_fire, skid_valid_reg)
    `ASSERT_IMP(a_singular_zero, m_valid_reg && !m_user_reg[0],
                (m_data_reg == '0) && !m_user_reg[1])

endmodule

[hdl/ls2_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ls2_div_cell
// One restoring division step for both numerators against a shared divisor.
// ----------------------------------------------------------------------------
module ls2_div_cell
    import ls2_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  div_word_t in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;
    logic [PROD_W:0] t0, t1, dd;

    always_comb begin
        word_next = in_word;
        dd = {1'b0, in_word.d};
        t0 = {in_word.r0, in_word.q0[QBITS-1]};
        t1 = {in_word.r1, in_word.q1[QBITS-1]};
        // subtract when the shifted remainder covers the divisor
        if (t0 >= dd) begin
            word_next.r0 = PROD_W'(t0 - dd);
            word_next.q0 = {in_word.q0[QBITS-2:0], 1'b1};
        end else begin
            word_next.r0 = t0[PROD_W-1:0];
            word_next.q0 = {in_word.q0[QBITS-2:0], 1'b0};
        end
        if (t1 >= dd) begin
            word_next.r1 = PROD_W'(t1 - dd);
            word_next.q1 = {in_word.q1[QBITS-2:0], 1'b1};
        end else begin
            word_next.r1 = t1[PROD_W-1:0];
            word_next.q1 = {in_word.q1[QBITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_solve_2x2: drives random and corner-case
// 2x2 systems, predicts each solution by Cramer's rule with exact long
// division, and compares every result word in order.
// ----------------------------------------------------------------------------
module tb;
    import ls2_pkg::*;

    localparam int LATENCY = 36;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] x0;
        logic [31:0] x1;
        logic        solved;
        logic        sat;
    } solution_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // x0, x1 from bit 0 up
    logic [1:0]   m_tuser;   // solved, saturated from bit 0 up
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;

    logic [191:0] pending_systems[$];
    solution_t    expected_solutions[$];
    logic [31:0]  threshold;
    int           errors;
    int           send_gap;
    int           sink_gap;
    bit           hold_sender;
    bit           idle_free;
    bit           in_taken;
    longint       cycles;

    linear_solve_2x2 dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Solve one element: (num << 16) / |det|, truncated, then clamped
    function automatic logic [31:0] solve_element(input logic signed [64:0] num,
                                                  input logic [63:0] dmag,
                                                  input bit dneg, inout bit sat);
        logic [64:0] nmag;
        logic [80:0] q;
        bit          neg;
        nmag = num[64] ? -num : num;
        q    = {nmag, 16'd0} / dmag;
        neg  = (num[64] != dneg) && q != 0;
        if (!neg) begin
            if (q > 81'h7FFF_FFFF) begin
                sat = 1;
                return POS_MAX;
            end
            return q[31:0];
        end
        if (q > 81'h8000_0000) begin
            sat = 1;
            return NEG_MIN;
        end
        return -q[31:0];
    endfunction

    function automatic solution_t cramer_solve(input logic [191:0] w);
        logic signed [31:0] a00, a01, a10, a11, b0, b1;
        logic signed [64:0] det, n0, n1;
        logic [64:0]        dmag;
        solution_t          s;
        bit                 sat;
        {b1, b0, a11, a10, a01, a00} = w;
        det  = 65'(a00 * 64'(a11)) - 65'(a01 * 64'(a10));
        n0   = 65'(a11 * 64'(b0)) - 65'(a01 * 64'(b1));
        n1   = 65'(a00 * 64'(b1)) - 65'(a10 * 64'(b0));
        dmag = det[64] ? -det : det;
        s    = '{default: '0};
        sat  = 0;
        if (dmag == 0 || dmag < threshold) return s;
        s.x0     = solve_element(n0, dmag[63:0], det[64], sat);
        s.x1     = solve_element(n1, dmag[63:0], det[64], sat);
        s.solved = 1;
        s.sat    = sat;
        return s;
    endfunction

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1023)) << 16 : 32'h0;
            3: return 32'($signed($urandom_range(0, 511)) - 256) << 16;
            4: return 32'($signed($urandom_range(0, 4095)) - 2048);
            default: return $urandom;
        endcase
    endfunction

    // Driver: advance one word per accepted handshake, insert random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // hold the word until it is taken
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_systems.size() > 0 && !hold_sender) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_systems.pop_front();
            if (!idle_free)
                send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                        : $urandom_range(0, 2);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Sink stalls, drawn at random
    always @(negedge aclk) begin
        if (!aresetn || idle_free) begin
            m_tready <= 1'b1;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50)
                                                        : $urandom_range(1, 3);
        end
    end

    // Predict at input acceptance, check at output acceptance
    always @(posedge aclk) begin
        solution_t e;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (s_tvalid && s_tready)
                expected_solutions.push_back(cramer_solve(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_solutions.size() == 0) begin
                    $error("unexpected result word x0=%h x1=%h", m_tdata[31:0],
                           m_tdata[63:32]);
                    errors++;
                end else begin
                    e = expected_solutions.pop_front();
                    if (m_tuser[0] !== e.solved) begin
                        $error("solved: expected %0b actual %0b", e.solved, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[31:0] !== e.x0) begin
                        $error("x0: expected %h actual %h", e.x0, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== e.x1) begin
                        $error("x1: expected %h actual %h", e.x1, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tuser[1] !== e.sat) begin
                        $error("saturated: expected %0b actual %0b", e.sat, m_tuser[1]);
                        errors++;
                    end
                end
            end
        end
    end

    // Abort on a hung pipeline
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_system(input logic [31:0] a00, a01, a10, a11, b0, b1);
        pending_systems.push_back({b1, b0, a11, a10, a01, a00});
    endtask

    task automatic queue_random(input int n);
        logic [31:0] e[6];
        int          k;
        for (int i = 0; i < n; i++) begin
            foreach (e[j]) e[j] = random_element();
            k = $urandom_range(0, 7);
            // steer some systems onto a tiny or exactly zero determinant
            if (k == 0) begin
                e[2] = e[0];
                e[3] = e[1];
            end else if (k == 1) begin
                e[0] = 32'($urandom_range(1, 300));
                e[3] = 32'($urandom_range(1, 300));
                e[1] = 32'h0;
            end
            queue_system(e[0], e[1], e[2], e[3], e[4], e[5]);
        end
    endtask

    // Let the pipeline drain before touching the register
    task automatic drain();
        wait (pending_systems.size() == 0 && !s_tvalid);
        wait (expected_solutions.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [31:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        threshold    = v;
    endtask

    initial begin
        logic [31:0] one;
        one         = 32'h0001_0000;
        errors      = 0;
        cycles      = 0;
        send_gap    = 0;
        sink_gap    = 0;
        hold_sender = 0;
        idle_free   = 0;
        threshold   = THR_RESET;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: identity, singular, extremes, saturation both ways
        queue_system(one, 0, 0, one, 32'h0003_0000, 32'hFFFD_0000);
        queue_system(one, one, one, one, one, one);
        queue_system(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_system(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_system(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
        queue_system(32'd1, 0, 0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_system(32'd300, 0, 0, 32'd300, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_system(32'd143, 0, 0, 32'd300, one, one);
        queue_system(32'd144, 0, 0, 32'd300, one, one);
        queue_system(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        queue_system(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
                     32'h0005_0000, 32'h000A_0000);
        queue_system(32'h0000_8000, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_system(32'hFFFF_0000, 0, 0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000);
        drain();

        // Zero threshold: only a zero determinant is singular
        write_threshold(32'h0);
        queue_system(0, 0, 0, 0, one, one);
        queue_system(32'd1, 0, 0, 32'd1, 32'h7FFF_FFFF, 32'd5);
        queue_random(150);
        drain();

        // Full-scale threshold, then a mid value
        write_threshold(32'hFFFF_FFFF);
        queue_system(32'h0001_0000, 0, 0, 32'h0001_0000, one, one);
        queue_system(32'h0001_0000, 0, 0, 32'h0000_FFFF, one, one);
        queue_random(150);
        drain();
        write_threshold($urandom);
        queue_random(150);

        // Hold off the sender until the pipeline is empty, then resume
        hold_sender = 1;
        wait (!s_tvalid);
        wait (expected_solutions.size() == 0);
        hold_sender = 0;
        drain();

        // Back to the reset value, one stretch with no idling
        write_threshold(THR_RESET);
        idle_free = 1;
        queue_random(100);
        drain();
        idle_free = 0;
        queue_random(250);
        drain();

        if (errors == 0 && expected_solutions.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/ls2_pkg.sv
hdl/ls2_div_cell.sv
hdl/linear_solve_2x2.sv
sim/tb.sv
